// ===== hdl/gdda_pkg.sv =====
package gdda_pkg;

  localparam int CELL_BITS = 6;
  localparam int DIST_BITS = 32;
  localparam int MAP_WIDTH_DEF = 64;
  localparam int MAP_HEIGHT_DEF = 64;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_BITS = 144;
  localparam int OUT_DATA_BITS = 80;

  typedef logic [DIST_BITS-1:0] dist_t;

  localparam dist_t DIST_INF = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } cmd_t;

  typedef enum logic {
    SIDE_X = 1'b0,
    SIDE_Y = 1'b1
  } side_t;

  typedef enum logic [1:0] {
    FACE_EAST  = 2'd0,
    FACE_WEST  = 2'd1,
    FACE_SOUTH = 2'd2,
    FACE_NORTH = 2'd3
  } facing_t;

  // Result of one walk step from the shared step unit.
  typedef struct packed {
    side_t side;
    logic  leave;
    dist_t acc;
  } step_res_t;

  function automatic facing_t facing_of(side_t side, logic x_pos, logic y_pos);
    facing_t f;
    if (side == SIDE_X) begin
      f = x_pos ? FACE_EAST : FACE_WEST;
    end else begin
      f = y_pos ? FACE_SOUTH : FACE_NORTH;
    end
    return f;
  endfunction

endpackage

// ===== hdl/gdda_ram.sv =====
module gdda_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/gdda_step.sv =====
module gdda_step #(
  parameter int MAP_WIDTH = gdda_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = gdda_pkg::MAP_HEIGHT_DEF,
  parameter int XW = 6,
  parameter int YW = 6
) (
  input  gdda_pkg::dist_t     acc_x,
  input  gdda_pkg::dist_t     acc_y,
  input  gdda_pkg::dist_t     delta_x,
  input  gdda_pkg::dist_t     delta_y,
  input  logic [XW-1:0]       walk_x,
  input  logic [YW-1:0]       walk_y,
  input  logic                x_pos,
  input  logic                y_pos,
  output gdda_pkg::step_res_t res,
  output logic [XW-1:0]       next_x,
  output logic [YW-1:0]       next_y
);

  gdda_pkg::side_t                side;
  gdda_pkg::dist_t                op_a;
  gdda_pkg::dist_t                op_b;
  logic [gdda_pkg::DIST_BITS:0]   sum;
  logic                           edge_x;
  logic                           edge_y;

  // Ties go to y.
  assign side = (acc_x < acc_y) ? gdda_pkg::SIDE_X : gdda_pkg::SIDE_Y;
  assign op_a = (side == gdda_pkg::SIDE_X) ? acc_x : acc_y;
  assign op_b = (side == gdda_pkg::SIDE_X) ? delta_x : delta_y;
  assign sum  = {1'b0, op_a} + {1'b0, op_b};

  assign edge_x = x_pos ? ({1'b0, walk_x} >= (XW+1)'(MAP_WIDTH - 1)) : (walk_x == '0);
  assign edge_y = y_pos ? ({1'b0, walk_y} >= (YW+1)'(MAP_HEIGHT - 1)) : (walk_y == '0);

  always_comb begin
    res.side  = side;
    res.acc   = sum[gdda_pkg::DIST_BITS] ? gdda_pkg::DIST_INF
                                         : sum[gdda_pkg::DIST_BITS-1:0];
    res.leave = (side == gdda_pkg::SIDE_X) ? edge_x : edge_y;
    next_x    = walk_x;
    next_y    = walk_y;
    if (side == gdda_pkg::SIDE_X) begin
      next_x = x_pos ? walk_x + XW'(1) : walk_x - XW'(1);
    end else begin
      next_y = y_pos ? walk_y + YW'(1) : walk_y - YW'(1);
    end
  end

endmodule

// ===== hdl/grid_dda_ray_traversal.sv =====
// Map write: the request passes through the START and FINISH states before its result is registered.
// Ray cast: the walk does one map read per step through the shared step unit and ends when a wall
// is read or the next step would leave the map.
// One request is in work at a time; the next is taken once its result sits in the output register.
// Reset (synchronous, active high) starts a clearing pass over all MAP_WIDTH * MAP_HEIGHT cells
// (4096 by default) that empties the wall map while s_tready stays low.
module grid_dda_ray_traversal #(
  parameter int MAP_WIDTH = gdda_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = gdda_pkg::MAP_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // cell_x, cell_y, wall_bit, x_step_positive, y_step_positive,
  // start_side_x, start_side_y, delta_x, delta_y, zero pad
  input  logic [gdda_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // command
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // hit_cell_x, hit_cell_y, hit_side, facing, end_side_x, end_side_y, left_grid
  output logic [gdda_pkg::OUT_DATA_BITS-1:0] m_tdata,
  // write_ack
  output logic                               m_tuser
);

  localparam int XW = ($clog2(MAP_WIDTH) > gdda_pkg::CELL_BITS) ? $clog2(MAP_WIDTH)
                                                               : gdda_pkg::CELL_BITS;
  localparam int YW = ($clog2(MAP_HEIGHT) > gdda_pkg::CELL_BITS) ? $clog2(MAP_HEIGHT)
                                                                : gdda_pkg::CELL_BITS;
  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW = $clog2(DEPTH);

  gdda_pkg::state_t    state;
  gdda_pkg::state_t    state_next;
  logic [AW-1:0]       clr_cnt;
  gdda_pkg::cmd_t      cmd;
  logic                wall;
  logic                x_pos;
  logic                y_pos;
  logic [XW-1:0]       walk_x;
  logic [YW-1:0]       walk_y;
  gdda_pkg::dist_t     acc_x;
  gdda_pkg::dist_t     acc_y;
  gdda_pkg::dist_t     delta_x;
  gdda_pkg::dist_t     delta_y;
  gdda_pkg::side_t     last_side;
  logic                left;
  logic                probe;

  gdda_pkg::step_res_t step;
  logic [XW-1:0]       next_x;
  logic [YW-1:0]       next_y;
  logic                in_map;
  logic                hit;
  logic                slot_free;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic                ram_rdata;

  gdda_step #(
    .MAP_WIDTH (MAP_WIDTH),
    .MAP_HEIGHT(MAP_HEIGHT),
    .XW        (XW),
    .YW        (YW)
  ) u_step (
    .acc_x  (acc_x),
    .acc_y  (acc_y),
    .delta_x(delta_x),
    .delta_y(delta_y),
    .walk_x (walk_x),
    .walk_y (walk_y),
    .x_pos  (x_pos),
    .y_pos  (y_pos),
    .res    (step),
    .next_x (next_x),
    .next_y (next_y)
  );

  gdda_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_map    = ({1'b0, walk_x} < (XW+1)'(MAP_WIDTH)) &&
                     ({1'b0, walk_y} < (YW+1)'(MAP_HEIGHT));
  // The read data belongs to the cell entered by the previous step.
  assign hit       = probe && ram_rdata;
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == gdda_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      gdda_pkg::ST_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = gdda_pkg::ST_IDLE;
        end
      end
      gdda_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = gdda_pkg::ST_START;
        end
      end
      gdda_pkg::ST_START: begin
        if (cmd == gdda_pkg::CMD_CAST && in_map) begin
          state_next = gdda_pkg::ST_WALK;
        end else begin
          state_next = gdda_pkg::ST_FINISH;
        end
      end
      gdda_pkg::ST_WALK: begin
        if (hit || step.leave) begin
          state_next = gdda_pkg::ST_FINISH;
        end
      end
      gdda_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_next = gdda_pkg::ST_IDLE;
        end
      end
      default: state_next = gdda_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = AW'(next_y) * AW'(MAP_WIDTH) + AW'(next_x);
    case (state)
      gdda_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      gdda_pkg::ST_START: begin
        ram_we    = (cmd == gdda_pkg::CMD_WRITE) && in_map;
        ram_waddr = AW'(walk_y) * AW'(MAP_WIDTH) + AW'(walk_x);
        ram_wdata = wall;
      end
      gdda_pkg::ST_WALK: begin
        ram_re = !hit && !step.leave;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gdda_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      probe    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gdda_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == gdda_pkg::ST_START) begin
        probe <= 1'b0;
      end else if (state == gdda_pkg::ST_WALK && !hit) begin
        probe <= !step.leave;
      end
      if (state == gdda_pkg::ST_FINISH && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gdda_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd       <= gdda_pkg::cmd_t'(s_tuser);
          walk_x    <= XW'(s_tdata[5:0]);
          walk_y    <= YW'(s_tdata[11:6]);
          wall      <= s_tdata[12];
          x_pos     <= s_tdata[13];
          y_pos     <= s_tdata[14];
          acc_x     <= s_tdata[46:15];
          acc_y     <= s_tdata[78:47];
          delta_x   <= s_tdata[110:79];
          delta_y   <= s_tdata[142:111];
          last_side <= gdda_pkg::SIDE_X;
          left      <= 1'b0;
        end
      end
      gdda_pkg::ST_START: begin
        if (!in_map) begin
          left <= 1'b1;
        end
      end
      gdda_pkg::ST_WALK: begin
        if (!hit) begin
          last_side <= step.side;
          if (step.side == gdda_pkg::SIDE_X) begin
            acc_x <= step.acc;
          end else begin
            acc_y <= step.acc;
          end
          if (step.leave) begin
            left <= 1'b1;
          end else begin
            walk_x <= next_x;
            walk_y <= next_y;
          end
        end
      end
      gdda_pkg::ST_FINISH: begin
        if (slot_free) begin
          if (cmd == gdda_pkg::CMD_WRITE) begin
            m_tdata <= '0;
            m_tuser <= 1'b1;
          end else begin
            m_tdata <= {left, acc_y, acc_x,
                        gdda_pkg::facing_of(last_side, x_pos, y_pos), last_side,
                        walk_y[gdda_pkg::CELL_BITS-1:0], walk_x[gdda_pkg::CELL_BITS-1:0]};
            m_tuser <= 1'b0;
          end
        end
      end
      default: begin
        left <= left;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_tready)
    else $error("request taken before the map clearing pass");

  a_walk_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == gdda_pkg::ST_WALK) |-> in_map)
    else $error("walk position outside the map");

  a_hit_stops: assert property (@(posedge clk) disable iff (rst)
    (state == gdda_pkg::ST_WALK && hit) |=> (state == gdda_pkg::ST_FINISH && !left))
    else $error("wall cell did not end the walk");

  a_ack_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("write result carries cast data");

  a_facing_side: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      ((m_tdata[12] == 1'b0) ==
       ((m_tdata[14:13] == gdda_pkg::FACE_EAST) || (m_tdata[14:13] == gdda_pkg::FACE_WEST))))
    else $error("facing does not match the side hit");
`endif

endmodule
